// ===== sv/tgpg_pkg.sv =====
// Package for the tensor grid point generator.
// Holds shared field widths, function and register codes, state and command types.
// Depends on nothing; every other file in this block imports it.
package tgpg_pkg;

    // Fixed field widths of the ports.
    localparam int FUNC_W     = 2;
    localparam int ENTRY_W    = 4;
    localparam int WORD_W     = 32;
    localparam int AXIS_W     = 3;
    localparam int DIM_W      = 4;
    localparam int NODES_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Fraction bits of the Q8.24 format.
    localparam int FRAC_BITS = 24;

    // Function codes carried by a request transaction.
    localparam logic [FUNC_W-1:0] FN_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_EMIT    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RESTART = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES      = 1'd1;
    localparam logic [DIM_W-1:0]     DIM_RESET      = 4'd2;
    localparam logic [NODES_W-1:0]   NODES_RESET    = 5'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WREAD,
        ST_WMUL,
        ST_WRND,
        ST_SEND
    } tgpg_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic restart;
        logic start;
        logic wread;
        logic wfirst;
        logic wmul;
        logic wrnd;
        logic send;
        logic step;
    } tgpg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic axis_last;
        logic out_free;
    } tgpg_status_t;

endpackage

// ===== sv/tgpg_ctrl.sv =====
// Controller of the tensor grid point generator.
// Sequences weight accumulation and result emission over the axes of one point.
// Depends on tgpg_pkg.
module tgpg_ctrl #(
    parameter int MAX_AXES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [tgpg_pkg::FUNC_W-1:0]   func,
    input  tgpg_pkg::tgpg_status_t        status,
    output tgpg_pkg::tgpg_cmd_t           cmd,
    output logic [$clog2(MAX_AXES)-1:0]   axis_idx
);
    import tgpg_pkg::*;

    localparam int AXW = $clog2(MAX_AXES);

    tgpg_state_t     state_reg;
    tgpg_state_t     state_next;
    logic [AXW-1:0]  axis_reg;
    logic [AXW-1:0]  axis_next;
    logic            req_fire;

    assign req_fire = req_valid && (state_reg == ST_IDLE);

    // State and axis counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // Next state and next axis.
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (func == FN_EMIT))
                begin
                    state_next = ST_WREAD;
                    axis_next  = '0;
                end
            end
            ST_WREAD:
            begin
                state_next = ST_WMUL;
            end
            ST_WMUL:
            begin
                if (axis_reg == '0)
                begin
                    // The first axis only loads its weight; at least two axes are active.
                    state_next = ST_WREAD;
                    axis_next  = axis_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_WRND;
                end
            end
            ST_WRND:
            begin
                if (status.axis_last)
                begin
                    state_next = ST_SEND;
                    axis_next  = '0;
                end
                else
                begin
                    state_next = ST_WREAD;
                    axis_next  = axis_reg + 1'b1;
                end
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    if (status.axis_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd         = '0;
        cmd.load    = req_fire && (func == FN_LOAD);
        cmd.restart = req_fire && (func == FN_RESTART);
        cmd.start   = req_fire && (func == FN_EMIT);
        cmd.wread   = (state_reg == ST_WREAD);
        cmd.wfirst  = (state_reg == ST_WMUL) && (axis_reg == '0);
        cmd.wmul    = (state_reg == ST_WMUL) && (axis_reg != '0);
        cmd.wrnd    = (state_reg == ST_WRND);
        cmd.send    = (state_reg == ST_SEND) && status.out_free;
        cmd.step    = (state_reg == ST_SEND) && status.out_free && status.axis_last;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign axis_idx  = axis_reg;

endmodule

// ===== sv/tgpg_datapath.sv =====
// Datapath of the tensor grid point generator.
// Holds configuration, node and weight tables, axis digits, the weight multiplier
// and the result register. Depends on tgpg_pkg.
module tgpg_datapath #(
    parameter int MAX_AXES   = 8,
    parameter int MAX_NODES  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tgpg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tgpg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [tgpg_pkg::ENTRY_W-1:0]     entry_index,
    input  logic signed [tgpg_pkg::WORD_W-1:0] node_value,
    input  logic signed [tgpg_pkg::WORD_W-1:0] weight_value,
    input  tgpg_pkg::tgpg_cmd_t              cmd,
    input  logic [$clog2(MAX_AXES)-1:0]      axis_idx,
    output tgpg_pkg::tgpg_status_t           status,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic [tgpg_pkg::AXIS_W-1:0]      axis,
    output logic signed [tgpg_pkg::WORD_W-1:0] coordinate,
    output logic signed [tgpg_pkg::WORD_W-1:0] point_weight,
    output logic                             weight_saturated,
    output logic                             last_of_point,
    output logic                             last_point_of_grid
);
    import tgpg_pkg::*;

    localparam int AXW     = $clog2(MAX_AXES);
    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int VW      = (VALUE_BITS > WORD_W) ? WORD_W : VALUE_BITS;
    localparam logic signed [63:0] VMAX     = (64'sd1 <<< (VW - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN     = -VMAX - 64'sd1;
    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    // Clip a wide signed value into the stored value range.
    function automatic logic signed [VW-1:0] sat_fn(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            if (v > VMAX)
            begin
                r = VMAX;
            end
            else if (v < VMIN)
            begin
                r = VMIN;
            end
            else
            begin
                r = v;
            end
            return VW'(r);
        end
    endfunction

    logic [DIM_W-1:0]         dims_reg;
    logic [NODES_W-1:0]       nodes_reg;
    logic [AXW-1:0]           dm1;
    logic [NODE_AW-1:0]       nm1;

    logic signed [VW-1:0]     node_mem [MAX_NODES];
    logic signed [VW-1:0]     weight_mem [MAX_NODES];
    logic                     load_ok;
    logic [NODE_AW-1:0]       load_addr;

    logic [NODE_AW-1:0]       digits_reg [MAX_AXES];
    logic [NODE_AW-1:0]       dig_step [MAX_AXES];
    logic [NODE_AW-1:0]       cur_dig;
    logic                     carry;

    logic signed [VW-1:0]     wt_rd_reg;
    logic signed [VW-1:0]     w_reg;
    logic signed [2*VW-1:0]   prod_reg;
    logic signed [63:0]       rnd_sum;
    logic signed [63:0]       rnd_shift;
    logic                     rnd_clip;
    logic                     clip_reg;
    logic                     lastg_reg;

    logic                     rsp_valid_reg;
    logic [AXIS_W-1:0]        axis_reg;
    logic signed [WORD_W-1:0] coord_reg;
    logic signed [WORD_W-1:0] pw_reg;
    logic                     sat_reg;
    logic                     lop_reg;
    logic                     lpg_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg  <= DIM_RESET;
            nodes_reg <= NODES_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DIMENSIONS)
            begin
                dims_reg <= cfg_data[DIM_W-1:0];
            end
            else if (cfg_index == CFG_NODES)
            begin
                nodes_reg <= cfg_data[NODES_W-1:0];
            end
        end
    end

    // Effective last axis and last digit after clamping the configuration.
    always_comb
    begin
        if (dims_reg < DIM_W'(2))
        begin
            dm1 = AXW'(1);
        end
        else if (32'(dims_reg) > MAX_AXES)
        begin
            dm1 = AXW'(MAX_AXES - 1);
        end
        else
        begin
            dm1 = AXW'(dims_reg - 1'b1);
        end

        if (nodes_reg == '0)
        begin
            nm1 = '0;
        end
        else if (32'(nodes_reg) > MAX_NODES)
        begin
            nm1 = NODE_AW'(MAX_NODES - 1);
        end
        else
        begin
            nm1 = NODE_AW'(nodes_reg - 1'b1);
        end
    end

    assign status.axis_last = (axis_idx == dm1);
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

    assign load_ok   = (32'(entry_index) < MAX_NODES);
    assign load_addr = NODE_AW'(entry_index);
    assign cur_dig   = digits_reg[axis_idx];

    // Node table; its read port feeds the result coordinate register.
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            node_mem[load_addr] <= sat_fn(64'(node_value));
        end
        if (cmd.send)
        begin
            coord_reg <= WORD_W'(node_mem[cur_dig]);
        end
    end

    // Weight table with registered read for the multiply chain.
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            weight_mem[load_addr] <= sat_fn(64'(weight_value));
        end
        if (cmd.wread)
        begin
            wt_rd_reg <= weight_mem[cur_dig];
        end
    end

    // Mixed-radix increment: the last active axis counts fastest, carries move up.
    always_comb
    begin
        carry = 1'b1;
        for (int j = MAX_AXES - 1; j >= 0; j--)
        begin
            dig_step[j] = digits_reg[j];
            if ((AXW'(j) <= dm1) && carry)
            begin
                if (digits_reg[j] >= nm1)
                begin
                    dig_step[j] = '0;
                end
                else
                begin
                    dig_step[j] = digits_reg[j] + 1'b1;
                    carry       = 1'b0;
                end
            end
        end
    end

    // Axis digit registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_AXES; j++)
            begin
                digits_reg[j] <= '0;
            end
        end
        else if (cmd.restart)
        begin
            for (int j = 0; j < MAX_AXES; j++)
            begin
                digits_reg[j] <= '0;
            end
        end
        else if (cmd.step)
        begin
            for (int j = 0; j < MAX_AXES; j++)
            begin
                digits_reg[j] <= dig_step[j];
            end
        end
    end

    // Round to nearest with ties upward, then clip.
    always_comb
    begin
        rnd_sum   = 64'(prod_reg) + RND_HALF;
        rnd_shift = rnd_sum >>> FRAC_BITS;
        rnd_clip  = (rnd_shift > VMAX) || (rnd_shift < VMIN);
    end

    // Weight accumulation: the first axis loads its weight; each further axis takes one multiply, then one round.
    always_ff @(posedge clk)
    begin
        if (cmd.wfirst)
        begin
            w_reg <= wt_rd_reg;
        end
        else if (cmd.wrnd)
        begin
            w_reg <= sat_fn(rnd_shift);
        end
        if (cmd.wmul)
        begin
            prod_reg <= w_reg * wt_rd_reg;
        end
    end

    // Per-point flags: saturation seen and every active digit at its last value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg  <= 1'b0;
            lastg_reg <= 1'b1;
        end
        else if (cmd.start)
        begin
            clip_reg  <= 1'b0;
            lastg_reg <= 1'b1;
        end
        else
        begin
            if (cmd.wrnd && rnd_clip)
            begin
                clip_reg <= 1'b1;
            end
            if (cmd.wread && (cur_dig < nm1))
            begin
                lastg_reg <= 1'b0;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.send)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.send)
        begin
            axis_reg <= AXIS_W'(axis_idx);
            pw_reg   <= WORD_W'(w_reg);
            sat_reg  <= clip_reg;
            lop_reg  <= status.axis_last;
            lpg_reg  <= lastg_reg;
        end
    end

    assign rsp_valid          = rsp_valid_reg;
    assign axis               = axis_reg;
    assign coordinate         = coord_reg;
    assign point_weight       = pw_reg;
    assign weight_saturated   = sat_reg;
    assign last_of_point      = lop_reg;
    assign last_point_of_grid = lpg_reg;

endmodule

// ===== sv/tensor_grid_point_generator_unit.sv =====
// Top level of the tensor grid point generator.
// Joins the controller (tgpg_ctrl) and the datapath (tgpg_datapath); uses tgpg_pkg.
//
// Channel   Handshake                 Payload
// request   req_valid / req_ready     func, entry_index, node_value, weight_value
// result    rsp_valid / rsp_ready     axis, coordinate, point_weight, weight_saturated,
//                                     last_of_point, last_point_of_grid
// config    cfg_we (no wait)          cfg_index, cfg_data
//
// Load and restart transactions leave req_ready high. A grid point over d axes runs, from
// its acceptance until the next request can be taken, through the accepting state, a table
// read and load for axis 0, a table read, multiply and round and clip for each further axis,
// then one result per cycle while the consumer is ready.
// Reset (rst_n, asynchronous, active low) clears the axis digits and sets dimensions
// and nodes_per_axis to 2; the node and weight tables hold nothing until loaded.
// A stalled result holds in the result register; the next request is taken while the
// final result of a point still waits.
module tensor_grid_point_generator_unit #(
    parameter int MAX_AXES   = 8,
    parameter int MAX_NODES  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tgpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgpg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [tgpg_pkg::FUNC_W-1:0]        func,
    input  logic [tgpg_pkg::ENTRY_W-1:0]       entry_index,
    input  logic signed [tgpg_pkg::WORD_W-1:0] node_value,
    input  logic signed [tgpg_pkg::WORD_W-1:0] weight_value,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic [tgpg_pkg::AXIS_W-1:0]        axis,
    output logic signed [tgpg_pkg::WORD_W-1:0] coordinate,
    output logic signed [tgpg_pkg::WORD_W-1:0] point_weight,
    output logic                               weight_saturated,
    output logic                               last_of_point,
    output logic                               last_point_of_grid
);
    import tgpg_pkg::*;

    localparam int AXW = $clog2(MAX_AXES);

    tgpg_cmd_t       cmd;
    tgpg_status_t    status;
    logic [AXW-1:0]  axis_idx;

    // Controller.
    tgpg_ctrl #(
        .MAX_AXES (MAX_AXES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .func      (func),
        .status    (status),
        .cmd       (cmd),
        .axis_idx  (axis_idx)
    );

    // Datapath.
    tgpg_datapath #(
        .MAX_AXES   (MAX_AXES),
        .MAX_NODES  (MAX_NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .entry_index        (entry_index),
        .node_value         (node_value),
        .weight_value       (weight_value),
        .cmd                (cmd),
        .axis_idx           (axis_idx),
        .status             (status),
        .rsp_valid          (rsp_valid),
        .rsp_ready          (rsp_ready),
        .axis               (axis),
        .coordinate         (coordinate),
        .point_weight       (point_weight),
        .weight_saturated   (weight_saturated),
        .last_of_point      (last_of_point),
        .last_point_of_grid (last_point_of_grid)
    );

    // No new request is taken while a point is still being emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && !last_of_point) |-> !req_ready)
        else $error("request accepted in the middle of a point");

    // Accepting a next-point transaction makes the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !req_ready)
        else $error("block still ready after a next-point transaction");

    // A result only appears after the controller loaded the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd.send))
        else $error("result valid without a send command");

    // While ready for requests, the weight chain and the emitter are quiet.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !(cmd.wread || cmd.wmul || cmd.wrnd || cmd.send))
        else $error("datapath busy while the block is ready");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for tensor_grid_point_generator_unit.
// Holds a scoreboard class that predicts every grid point result, plus the
// stimulus, consumer and checking processes; depends on tgpg_pkg and tensor_grid_point_generator_unit.
module tb_top;
    import tgpg_pkg::*;

    localparam int GRID_AXES   = 8;
    localparam int GRID_NODES  = 16;
    localparam int WORD_BITS   = 32;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 30;
    localparam int IDLE_TAIL   = 10;
    localparam int END_TAIL    = 100;
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;

    // Function code that the block ignores.
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] Q_ONE    = 32'sh0100_0000;

    // One expected result transaction.
    typedef struct {
        logic [AXIS_W-1:0]        axis;
        logic signed [WORD_W-1:0] coordinate;
        logic signed [WORD_W-1:0] point_weight;
        logic                     weight_saturated;
        logic                     last_of_point;
        logic                     last_point_of_grid;
    } axis_result_t;

    // Tracks the rule tables, the digit counter and the registers, and checks results.
    class grid_point_scoreboard;
        logic signed [WORD_W-1:0] node_tab [GRID_NODES];
        logic signed [WORD_W-1:0] weight_tab [GRID_NODES];
        logic [ENTRY_W-1:0]       axis_digit [GRID_AXES];
        logic [DIM_W-1:0]         dims_reg;
        logic [NODES_W-1:0]       nodes_reg;
        axis_result_t             pending_axis_results [$];
        int                       error_count;

        function new();
            foreach (node_tab[i])
            begin
                node_tab[i] = '0;
                weight_tab[i] = '0;
            end
            foreach (axis_digit[i])
                axis_digit[i] = '0;
            dims_reg = DIM_RESET;
            nodes_reg = NODES_RESET;
            error_count = 0;
        endfunction

        function int pending();
            return pending_axis_results.size();
        endfunction

        function void write_register(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DIMENSIONS)
                dims_reg = data[DIM_W-1:0];
            else if (idx == CFG_NODES)
                nodes_reg = data[NODES_W-1:0];
        endfunction

        // Q8.24 product, rounded to nearest with ties upward, clipped to 32 bits.
        function logic signed [WORD_W-1:0] mul_q824(input logic signed [WORD_W-1:0] a,
                                                    input logic signed [WORD_W-1:0] b,
                                                    inout bit clipped);
            logic signed [63:0] prod;
            logic signed [63:0] rounded;
            prod = 64'(a) * 64'(b);
            rounded = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (rounded > 64'sd2147483647)
            begin
                clipped = 1'b1;
                return WORD_MAX;
            end
            if (rounded < -64'sd2147483648)
            begin
                clipped = 1'b1;
                return WORD_MIN;
            end
            return rounded[WORD_W-1:0];
        endfunction

        // Expected results of one point, then the counter step.
        function void predict_point();
            axis_result_t             res;
            logic signed [WORD_W-1:0] acc;
            bit                       clipped;
            bit                       last_grid;
            int                       d;
            int                       n;
            int                       k;
            d = (dims_reg < 2) ? 2 : ((dims_reg > GRID_AXES) ? GRID_AXES : int'(dims_reg));
            n = (nodes_reg == 0) ? 1 :
                ((nodes_reg > GRID_NODES) ? GRID_NODES : int'(nodes_reg));
            clipped = 1'b0;
            last_grid = 1'b1;
            acc = weight_tab[axis_digit[0]];
            for (k = 0; k < d; k++)
            begin
                if (k > 0)
                    acc = mul_q824(acc, weight_tab[axis_digit[k]], clipped);
                if (axis_digit[k] < n - 1)
                    last_grid = 1'b0;
            end
            for (k = 0; k < d; k++)
            begin
                res.axis = k[AXIS_W-1:0];
                res.coordinate = node_tab[axis_digit[k]];
                res.point_weight = acc;
                res.weight_saturated = clipped;
                res.last_of_point = (k == d - 1);
                res.last_point_of_grid = last_grid;
                pending_axis_results.push_back(res);
            end
            // Last axis counts fastest; a stale digit above n-1 wraps like a final one.
            for (k = d - 1; k >= 0; k--)
            begin
                if (axis_digit[k] >= n - 1)
                    axis_digit[k] = '0;
                else
                begin
                    axis_digit[k] = axis_digit[k] + 1'b1;
                    break;
                end
            end
        endfunction

        function void note_request(input logic [FUNC_W-1:0] f,
                                   input logic [ENTRY_W-1:0] entry,
                                   input logic signed [WORD_W-1:0] node,
                                   input logic signed [WORD_W-1:0] weight);
            case (f)
                FN_LOAD:
                begin
                    node_tab[entry] = node;
                    weight_tab[entry] = weight;
                end
                FN_EMIT:
                    predict_point();
                FN_RESTART:
                    foreach (axis_digit[i])
                        axis_digit[i] = '0;
                default:
                    ;
            endcase
        endfunction

        function void compare_field(input string name, input logic signed [63:0] expected,
                                    input logic signed [63:0] actual);
            if (actual !== expected)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
                error_count++;
            end
        endfunction

        function void check_result(input logic [AXIS_W-1:0] ax,
                                   input logic signed [WORD_W-1:0] coord,
                                   input logic signed [WORD_W-1:0] pw,
                                   input logic sat, input logic lop, input logic lpg);
            axis_result_t exp_res;
            if (pending_axis_results.size() == 0)
            begin
                $error("result transaction on axis %0d with none expected", ax);
                error_count++;
                return;
            end
            exp_res = pending_axis_results.pop_front();
            compare_field("axis", exp_res.axis, ax);
            compare_field("coordinate", exp_res.coordinate, coord);
            compare_field("point_weight", exp_res.point_weight, pw);
            compare_field("weight_saturated", exp_res.weight_saturated, sat);
            compare_field("last_of_point", exp_res.last_of_point, lop);
            compare_field("last_point_of_grid", exp_res.last_point_of_grid, lpg);
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     req_valid;
    logic                     req_ready;
    logic [FUNC_W-1:0]        func;
    logic [ENTRY_W-1:0]       entry_index;
    logic signed [WORD_W-1:0] node_value;
    logic signed [WORD_W-1:0] weight_value;
    logic                     rsp_valid;
    logic                     rsp_ready;
    logic [AXIS_W-1:0]        axis;
    logic signed [WORD_W-1:0] coordinate;
    logic signed [WORD_W-1:0] point_weight;
    logic                     weight_saturated;
    logic                     last_of_point;
    logic                     last_point_of_grid;

    grid_point_scoreboard grid_sb;
    bit                   sender_eager;
    int                   cycle_count;

    tensor_grid_point_generator_unit #(
        .MAX_AXES  (GRID_AXES),
        .MAX_NODES (GRID_NODES),
        .VALUE_BITS(WORD_BITS)
    ) DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .req_valid         (req_valid),
        .req_ready         (req_ready),
        .func              (func),
        .entry_index       (entry_index),
        .node_value        (node_value),
        .weight_value      (weight_value),
        .rsp_valid         (rsp_valid),
        .rsp_ready         (rsp_ready),
        .axis              (axis),
        .coordinate        (coordinate),
        .point_weight      (point_weight),
        .weight_saturated  (weight_saturated),
        .last_of_point     (last_of_point),
        .last_point_of_grid(last_point_of_grid)
    );

    // Clock with a period of two time units.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int sender_gap();
        if (sender_eager)
            return 0;
        return pick_gap();
    endfunction

    // Extremes, values near one that keep products in range, and full-range noise.
    function automatic logic signed [WORD_W-1:0] random_word();
        logic signed [WORD_W-1:0] mag;
        case ($urandom_range(0, 9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3, 4, 5:
            begin
                mag = $urandom_range(0, 32'h0200_0000);
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: return $urandom();
        endcase
    endfunction

    // Offers one request transaction and waits until it is accepted.
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [ENTRY_W-1:0] e,
                                input logic signed [WORD_W-1:0] nv,
                                input logic signed [WORD_W-1:0] wv, input int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func <= f;
        entry_index <= e;
        node_value <= nv;
        weight_value <= wv;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        grid_sb.note_request(f, e, nv, wv);
    endtask

    // Stops offering until every expected result is in and a load has settled.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (grid_sb.pending() != 0)
            @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] dims_data,
                                  input logic [CFG_DATA_W-1:0] nodes_data);
        cfg_we <= 1'b1;
        cfg_index <= CFG_DIMENSIONS;
        cfg_data <= dims_data;
        @(posedge clk);
        grid_sb.write_register(CFG_DIMENSIONS, dims_data);
        cfg_index <= CFG_NODES;
        cfg_data <= nodes_data;
        @(posedge clk);
        grid_sb.write_register(CFG_NODES, nodes_data);
        cfg_we <= 1'b0;
    endtask

    // Checks every accepted result transaction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            grid_sb.check_result(axis, coordinate, point_weight, weight_saturated,
                                 last_of_point, last_point_of_grid);
    end

    // Result consumer: random stalls, long ready stretches and one long hold-off.
    initial
    begin
        int stall_left;
        int run_left;
        int results_seen;
        bit held;
        stall_left = 0;
        run_left = 0;
        results_seen = 0;
        held = 1'b0;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                results_seen++;
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
                else
                begin
                    stall_left = pick_gap();
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) :
                                                             $urandom_range(1, 10);
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus: reset, directed items, then random phases under varied settings.
    initial
    begin
        int                       phase;
        int                       item;
        int                       roll;
        logic signed [WORD_W-1:0] nv;
        logic signed [WORD_W-1:0] wv;
        logic [CFG_DATA_W-1:0]    dims_data;
        logic [CFG_DATA_W-1:0]    nodes_data;

        grid_sb = new();
        sender_eager = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DIMENSIONS;
        cfg_data = '0;
        req_valid = 1'b0;
        func = FN_LOAD;
        entry_index = '0;
        node_value = '0;
        weight_value = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Fill every table slot first so that no unwritten entry is ever read.
        for (item = 0; item < GRID_NODES; item++)
        begin
            case (item)
                0:
                begin
                    nv = WORD_MAX;
                    wv = WORD_MAX;
                end
                1:
                begin
                    nv = WORD_MIN;
                    wv = WORD_MIN;
                end
                2:
                begin
                    nv = '0;
                    wv = '0;
                end
                3:
                begin
                    nv = Q_ONE;
                    wv = Q_ONE;
                end
                4:
                begin
                    nv = -Q_ONE;
                    wv = -Q_ONE;
                end
                default:
                begin
                    nv = random_word();
                    wv = random_word();
                end
            endcase
            send_request(FN_LOAD, item[ENTRY_W-1:0], nv, wv, sender_gap());
        end

        // Whole 2x2 grid at reset settings, the wrap, an ignored code and a restart.
        repeat (5)
            send_request(FN_EMIT, ENTRY_W'($urandom()), $urandom(), $urandom(),
                         sender_gap());
        send_request(FN_UNUSED, ENTRY_W'($urandom()), $urandom(), $urandom(), sender_gap());
        send_request(FN_RESTART, ENTRY_W'($urandom()), $urandom(), $urandom(), sender_gap());
        send_request(FN_EMIT, ENTRY_W'($urandom()), $urandom(), $urandom(), sender_gap());

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            // Early phases hit the extremes and out-of-range codes; phase four
            // shrinks the grid without a restart, leaving stale digits.
            case (phase)
                0:
                begin
                    dims_data = 5'd2;
                    nodes_data = 5'd1;
                end
                1:
                begin
                    dims_data = 5'd8;
                    nodes_data = 5'd16;
                end
                2:
                begin
                    dims_data = 5'd0;
                    nodes_data = 5'd0;
                end
                3:
                begin
                    dims_data = 5'd31;
                    nodes_data = 5'd31;
                end
                4:
                begin
                    dims_data = 5'd3;
                    nodes_data = 5'd3;
                end
                default:
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        dims_data = CFG_DATA_W'($urandom_range(0, 31));
                        nodes_data = CFG_DATA_W'($urandom_range(0, 31));
                    end
                    else
                    begin
                        dims_data = CFG_DATA_W'($urandom_range(2, 8));
                        nodes_data = ($urandom_range(0, 5) == 0) ? 5'd16 :
                                                                   5'($urandom_range(1, 5));
                    end
                end
            endcase
            apply_settings(dims_data, nodes_data);
            sender_eager = (phase % 3 == 2);

            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                // Once, let the block empty out completely in mid-phase.
                if (phase == 7 && item == 15)
                    wait_idle();
                roll = $urandom_range(0, 99);
                if (item == 0 && phase >= 5 && $urandom_range(0, 1) == 1)
                    send_request(FN_RESTART, ENTRY_W'($urandom()), $urandom(), $urandom(),
                                 sender_gap());
                else if (roll < 70)
                    send_request(FN_EMIT, ENTRY_W'($urandom()), $urandom(), $urandom(),
                                 sender_gap());
                else if (roll < 90)
                    send_request(FN_LOAD, ENTRY_W'($urandom()), random_word(), random_word(),
                                 sender_gap());
                else if (roll < 96)
                    send_request(FN_RESTART, ENTRY_W'($urandom()), $urandom(), $urandom(),
                                 sender_gap());
                else
                    send_request(FN_UNUSED, ENTRY_W'($urandom()), $urandom(), $urandom(),
                                 sender_gap());
            end
        end

        wait_idle();
        repeat (END_TAIL) @(posedge clk);
        if (grid_sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
